// ----- rtl/core/rac_pkg.sv -----
// rac_pkg: shared types for the coalescing range allocator
// holds the request and result beat structs, the extent word and status codes
// no dependencies
`default_nettype none
package rac_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_FREE_IGN  = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_e;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // request beat
  typedef struct packed {
    logic        command;
    logic [31:0] size;
    logic [31:0] block_start;
    logic        best_fit;
  } req_t;

  // result beat
  typedef struct packed {
    status_e     status;
    logic [31:0] alloc_start;
    logic [31:0] alloc_len;
    logic [31:0] bytes_left;
  } res_t;

  // one free extent as stored in the extent memory
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } ext_t;

endpackage
`default_nettype wire

// ----- rtl/core/rac_ext_mem.sv -----
// rac_ext_mem: extent memory, one write port and one registered read port
// depends on rac_pkg for the extent word type
`default_nettype none
module rac_ext_mem #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  wire                  clk_i,
  input  wire                  re_i,
  input  wire [AddrW-1:0]      raddr_i,
  output rac_pkg::ext_t        rdata_o,
  input  wire                  we_i,
  input  wire [AddrW-1:0]      waddr_i,
  input  rac_pkg::ext_t        wdata_i
);
  import rac_pkg::*;

  ext_t mem_q [Depth];
  ext_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/range_allocator_coalescing.sv -----
// range_allocator_coalescing: first/best fit allocator over an address sorted free list
// run time grows with each extent scanned and each entry shifted on insert or remove
// throughput: one command at a time, busy is high until the result strobe
// reset: list holds one extent (0, 0), nothing allocated; no clearing pass is needed
// the receiver cannot stall, each result is shown for one cycle on res_valid_o
`default_nettype none
module range_allocator_coalescing #(
  parameter int MAX_EXTENTS = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start,
  output logic          busy,
  input  rac_pkg::req_t req_i,
  input  wire           cfg_we_i,
  input  wire [31:0]    cfg_wdata_i,
  output logic          res_valid_o,
  output rac_pkg::res_t res_o
);
  import rac_pkg::*;

  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_EXTENTS);
  localparam logic [CW-1:0] One = CW'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_ALLOC_WR, S_INS_RD, S_INS_WR, S_INS_FIN,
    S_FWR, S_CO_CHK, S_CO_PEV, S_CO_PWR, S_CO_NX, S_CO_NEV, S_CO_NWR,
    S_RM_CHK, S_RM_WR, S_RESP
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q, idx_q, j_q, pick_q;
  logic [31:0]   alloc_q, mem_size_q, end_q, a_start_q, a_len_q;
  logic          ovr0_q, found_q, coal_q, res_valid_q;
  logic [IW-1:0] raddr_q;
  req_t          req_q;
  ext_t          pick_e_q, prev_q, cur_q;
  status_e       status_q;
  res_t          res_q;

  logic          mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  ext_t          mem_wdata, mem_rdata, rdat;
  logic [CW-1:0] idxm1, idxp1, jm1, jp1;
  logic [31:0]   left, rel;

  assign idxm1 = idx_q - One;
  assign idxp1 = idx_q + One;
  assign jm1   = j_q - One;
  assign jp1   = j_q + One;
  assign left  = mem_size_q - alloc_q;
  assign rel   = (req_q.size > alloc_q) ? 32'd0 : alloc_q - req_q.size;

  rac_ext_mem #(
    .Depth (MAX_EXTENTS),
    .AddrW (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // entry 0 reads as the initial extent until it is first written
  assign rdat = (ovr0_q && raddr_q == '0) ? ext_t'{start: 32'd0, len: mem_size_q} : mem_rdata;

  // memory access per state
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_q[IW-1:0];
    mem_we    = 1'b0;
    mem_waddr = idx_q[IW-1:0];
    mem_wdata = cur_q;
    case (state_q)
      S_SCAN_RD: mem_re = 1'b1;
      S_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = jm1[IW-1:0];
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IW-1:0];
        mem_wdata = rdat;
      end
      S_INS_FIN: begin
        mem_we    = 1'b1;
        mem_wdata = ext_t'{start: req_q.block_start, len: req_q.size};
      end
      S_FWR, S_CO_NWR: mem_we = 1'b1;
      S_CO_CHK: begin
        mem_re    = (idx_q != '0);
        mem_raddr = idxm1[IW-1:0];
      end
      S_CO_PWR: begin
        mem_we    = 1'b1;
        mem_waddr = idxm1[IW-1:0];
      end
      S_CO_NX: begin
        mem_re    = (idxp1 < cnt_q);
        mem_raddr = idxp1[IW-1:0];
      end
      S_RM_CHK: begin
        mem_re    = (jp1 < cnt_q);
        mem_raddr = jp1[IW-1:0];
      end
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IW-1:0];
        mem_wdata = rdat;
      end
      S_ALLOC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pick_q[IW-1:0];
        mem_wdata = ext_t'{start: pick_e_q.start + req_q.size,
                           len: pick_e_q.len - req_q.size};
      end
      default: ;
    endcase
  end

  // sequencer, list bookkeeping and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= One;
      alloc_q     <= '0;
      mem_size_q  <= '0;
      ovr0_q      <= 1'b1;
      idx_q       <= '0;
      j_q         <= '0;
      pick_q      <= '0;
      found_q     <= 1'b0;
      coal_q      <= 1'b0;
      raddr_q     <= '0;
      end_q       <= '0;
      a_start_q   <= '0;
      a_len_q     <= '0;
      status_q    <= ST_OK;
      req_q       <= '0;
      pick_e_q    <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (mem_re) begin
        raddr_q <= mem_raddr;
      end
      if (mem_we && mem_waddr == '0) begin
        ovr0_q <= 1'b0;
      end
      // register write reinitializes the list
      if (cfg_we_i) begin
        mem_size_q <= cfg_wdata_i;
        cnt_q      <= One;
        alloc_q    <= '0;
        ovr0_q     <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q     <= req_i;
            a_start_q <= '0;
            a_len_q   <= '0;
            idx_q     <= '0;
            found_q   <= 1'b0;
            coal_q    <= 1'b0;
            end_q     <= req_i.block_start + req_i.size;
            if (req_i.command == CMD_ALLOC) begin
              if (req_i.size == '0 || req_i.size > left || cnt_q == '0) begin
                status_q <= ST_NO_SPACE;
                state_q  <= S_RESP;
              end else begin
                state_q <= S_SCAN_RD;
              end
            end else if (req_i.size == '0 || req_i.block_start >= mem_size_q) begin
              status_q <= ST_FREE_IGN;
              state_q  <= S_RESP;
            end else if (cnt_q == '0) begin
              state_q <= S_INS_FIN;
            end else begin
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_EV;
        S_SCAN_EV: begin
          prev_q <= rdat;
          if (req_q.command == CMD_ALLOC) begin
            if (rdat.len >= req_q.size && (!req_q.best_fit || rdat.len == req_q.size)) begin
              pick_q   <= idx_q;
              pick_e_q <= rdat;
              state_q  <= S_ALLOC_WR;
            end else begin
              if (rdat.len >= req_q.size && (!found_q || rdat.len < pick_e_q.len)) begin
                pick_q   <= idx_q;
                pick_e_q <= rdat;
                found_q  <= 1'b1;
              end
              if (idxp1 == cnt_q) begin
                if (found_q || rdat.len >= req_q.size) begin
                  state_q <= S_ALLOC_WR;
                end else begin
                  status_q <= ST_NO_SPACE;
                  state_q  <= S_RESP;
                end
              end else begin
                idx_q   <= idxp1;
                state_q <= S_SCAN_RD;
              end
            end
          end else if (rdat.start == end_q) begin
            // freed block ends where this extent starts
            cur_q   <= ext_t'{start: req_q.block_start, len: rdat.len + req_q.size};
            state_q <= S_FWR;
          end else if (rdat.start > end_q) begin
            if (idx_q != '0 && prev_q.start + prev_q.len == req_q.block_start) begin
              cur_q   <= ext_t'{start: prev_q.start, len: prev_q.len + req_q.size};
              idx_q   <= idxm1;
              state_q <= S_FWR;
            end else if (cnt_q == MaxCnt) begin
              status_q <= ST_LIST_FULL;
              state_q  <= S_RESP;
            end else begin
              j_q     <= cnt_q;
              state_q <= (cnt_q == idx_q) ? S_INS_FIN : S_INS_RD;
            end
          end else if (idxp1 == cnt_q) begin
            // past the last extent
            if (rdat.start + rdat.len == req_q.block_start) begin
              cur_q   <= ext_t'{start: rdat.start, len: rdat.len + req_q.size};
              state_q <= S_FWR;
            end else if (cnt_q == MaxCnt) begin
              status_q <= ST_LIST_FULL;
              state_q  <= S_RESP;
            end else begin
              idx_q   <= cnt_q;
              state_q <= S_INS_FIN;
            end
          end else begin
            idx_q   <= idxp1;
            state_q <= S_SCAN_RD;
          end
        end
        S_ALLOC_WR: begin
          alloc_q   <= alloc_q + req_q.size;
          a_start_q <= pick_e_q.start;
          a_len_q   <= req_q.size;
          status_q  <= ST_OK;
          if (pick_e_q.len == req_q.size) begin
            j_q     <= pick_q;
            state_q <= S_RM_CHK;
          end else begin
            state_q <= S_RESP;
          end
        end
        // shift entries up by one, top first
        S_INS_RD: state_q <= S_INS_WR;
        S_INS_WR: begin
          j_q     <= jm1;
          state_q <= (jm1 == idx_q) ? S_INS_FIN : S_INS_RD;
        end
        S_INS_FIN: begin
          cnt_q    <= cnt_q + One;
          status_q <= ST_OK;
          state_q  <= S_RESP;
        end
        S_FWR: begin
          coal_q  <= 1'b1;
          state_q <= S_CO_CHK;
        end
        // coalesce loop, previous neighbour first
        S_CO_CHK: state_q <= (idx_q != '0) ? S_CO_PEV : S_CO_NX;
        S_CO_PEV: begin
          if (rdat.start + rdat.len == cur_q.start) begin
            cur_q   <= ext_t'{start: rdat.start, len: rdat.len + cur_q.len};
            state_q <= S_CO_PWR;
          end else begin
            state_q <= S_CO_NX;
          end
        end
        S_CO_PWR: begin
          j_q     <= idx_q;
          idx_q   <= idxm1;
          state_q <= S_RM_CHK;
        end
        S_CO_NX: begin
          if (idxp1 < cnt_q) begin
            state_q <= S_CO_NEV;
          end else begin
            status_q <= ST_OK;
            state_q  <= S_RESP;
          end
        end
        S_CO_NEV: begin
          if (cur_q.start + cur_q.len == rdat.start) begin
            cur_q.len <= cur_q.len + rdat.len;
            state_q   <= S_CO_NWR;
          end else begin
            status_q <= ST_OK;
            state_q  <= S_RESP;
          end
        end
        S_CO_NWR: begin
          j_q     <= idxp1;
          state_q <= S_RM_CHK;
        end
        // remove entry j by shifting the tail down
        S_RM_CHK: begin
          if (jp1 < cnt_q) begin
            state_q <= S_RM_WR;
          end else begin
            cnt_q <= cnt_q - One;
            if (coal_q) begin
              state_q <= S_CO_CHK;
            end else begin
              status_q <= ST_OK;
              state_q  <= S_RESP;
            end
          end
        end
        S_RM_WR: begin
          j_q     <= jp1;
          state_q <= S_RM_CHK;
        end
        S_RESP: begin
          res_valid_q       <= 1'b1;
          res_q.status      <= status_q;
          res_q.alloc_start <= a_start_q;
          res_q.alloc_len   <= a_len_q;
          if (req_q.command == CMD_FREE && status_q == ST_OK) begin
            alloc_q          <= rel;
            res_q.bytes_left <= mem_size_q - rel;
          end else begin
            res_q.bytes_left <= left;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // extent count never exceeds the list capacity
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= MaxCnt)
    else $error("extent count overflow");

  // accepted command makes the block busy next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cfg_we_i) |=> busy)
    else $error("command accepted without going busy");

  // result strobe comes only out of the response state
  a_res_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == S_RESP))
    else $error("result strobe without response state");

  // a write never targets an index past the list end plus one
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} <= {1'b0, cnt_q}))
    else $error("extent write beyond list");

endmodule
`default_nettype wire
